// ----- src/awa_pkg.sv -----
// Shared constants, widths and the arctangent table for the wheel angle block.
package awa_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int STEP_MAX         = 24;

	localparam int YAW_W   = 8;
	localparam int LEN_W   = 12;
	localparam int DPP_W   = 16;
	localparam int ANG_W   = 16;
	localparam int PUL_W   = 24;
	localparam int CIDX_W  = 8;
	localparam int CDAT_W  = 16;

	localparam int ROT_W   = 34;  // Q30 sin/cos with headroom
	localparam int Z_W     = 25;  // Q.16 degrees
	localparam int PRD_W   = 47;  // 13 x 34 product
	localparam int DEN_W   = 48;
	localparam int VEC_W   = 50;
	localparam int MAG_W   = 15;
	localparam int DVD_W   = MAG_W + 8;

	localparam logic signed [ROT_W-1:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = 16'sd23040;
	localparam logic [DVD_W-1:0]        PULSE_LIMIT = 23'd5898240;
	localparam logic signed [YAW_W-1:0] YAW_MAX     = 8'sd90;
	localparam logic signed [YAW_W-1:0] YAW_MIN     = -8'sd90;

	localparam logic [LEN_W-1:0] WHEELBASE_RST = 12'd300;
	localparam logic [LEN_W-1:0] TRACK_RST     = 12'd250;
	localparam logic [DPP_W-1:0] DPP_RST       = 16'd7373;

	localparam logic [CIDX_W-1:0] REG_WHEELBASE = 8'd0;
	localparam logic [CIDX_W-1:0] REG_TRACK     = 8'd1;
	localparam logic [CIDX_W-1:0] REG_DPP       = 8'd2;

	// atan(2^-i) in units of 1/65536 degree, rounded
	function automatic logic [21:0] atan_q16(input int idx);
		logic [21:0] v;
		case (idx)
			0:  v = 22'd2949120;
			1:  v = 22'd1740967;
			2:  v = 22'd919879;
			3:  v = 22'd466945;
			4:  v = 22'd234379;
			5:  v = 22'd117304;
			6:  v = 22'd58666;
			7:  v = 22'd29335;
			8:  v = 22'd14668;
			9:  v = 22'd7334;
			10: v = 22'd3667;
			11: v = 22'd1833;
			12: v = 22'd917;
			13: v = 22'd458;
			14: v = 22'd229;
			15: v = 22'd115;
			16: v = 22'd57;
			17: v = 22'd29;
			18: v = 22'd14;
			19: v = 22'd7;
			20: v = 22'd4;
			21: v = 22'd2;
			22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/awa_if.sv -----
// Handshake channels: command, result and configuration write.
interface awa_cmd_if import awa_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [YAW_W-1:0] yaw_deg;
	modport source (output valid, output yaw_deg, input ready);
	modport sink (input valid, input yaw_deg, output ready);
endinterface

interface awa_res_if import awa_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [ANG_W-1:0] right_angle;
	logic signed [ANG_W-1:0] left_angle;
	logic signed [PUL_W-1:0] right_pulses;
	logic signed [PUL_W-1:0] left_pulses;
	modport source (output valid, output right_angle, output left_angle,
		output right_pulses, output left_pulses, input ready);
	modport sink (input valid, input right_angle, input left_angle,
		input right_pulses, input left_pulses, output ready);
endinterface

interface awa_cfg_if import awa_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [CDAT_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/ackermann_wheel_angles.sv -----
// Ackermann front wheel angles and stepper targets from a yaw command.
//  channel | dir | payload
//  cmd     | in  | yaw_deg
//  res     | out | right_angle, left_angle, right_pulses, left_pulses
//  cfg     | in  | index, data (wheelbase, track, degrees per pulse)
// Accepts one item per cycle while res is not stalled; the pipe runs through the
// rotation CORDIC, the two vectoring CORDICs and the 23-stage restoring divider.
// All stages advance together; a stalled result freezes the whole pipe.
// arst_n clears the valid bits and loads the register defaults.
module ackermann_wheel_angles import awa_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	awa_cmd_if.sink   cmd,
	awa_res_if.source res,
	awa_cfg_if.sink   cfg
);

	localparam int N = CORDIC_STEPS;

	logic [LEN_W-1:0] wb_q, tr_q;
	logic [DPP_W-1:0] dpp_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q  <= WHEELBASE_RST;
			tr_q  <= TRACK_RST;
			dpp_q <= DPP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WHEELBASE: wb_q  <= cfg.data[LEN_W-1:0];
				REG_TRACK:     tr_q  <= cfg.data[LEN_W-1:0];
				REG_DPP:       dpp_q <= cfg.data[DPP_W-1:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic res_valid_q;
	assign adv       = !res_valid_q || res.ready;
	assign cmd.ready = adv;

	// rotation CORDIC: sin/cos of yaw
	logic                    rot_v_s [0:N];
	logic                    rot_zero_s [0:N];
	logic signed [ROT_W-1:0] rot_x_s [0:N];
	logic signed [ROT_W-1:0] rot_y_s [0:N];
	logic signed [Z_W-1:0]   rot_z_s [0:N];

	logic signed [YAW_W-1:0] yaw_sat;
	always_comb begin
		yaw_sat = cmd.yaw_deg;
		if (cmd.yaw_deg > YAW_MAX) yaw_sat = YAW_MAX;
		if (cmd.yaw_deg < YAW_MIN) yaw_sat = YAW_MIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_v_s[0] <= 1'b0;
		end else if (adv) begin
			rot_v_s[0] <= cmd.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rot_zero_s[0] <= (yaw_sat == '0);
			rot_x_s[0]    <= GAIN_Q30;
			rot_y_s[0]    <= '0;
			rot_z_s[0]    <= {yaw_sat[YAW_W-1], yaw_sat, 16'b0};
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_rot
		localparam logic signed [Z_W-1:0] A = $signed({3'b0, atan_q16(k)});
		logic signed [ROT_W-1:0] xs, ys;
		assign xs = rot_x_s[k] >>> k;
		assign ys = rot_y_s[k] >>> k;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rot_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				rot_v_s[k+1] <= rot_v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rot_zero_s[k+1] <= rot_zero_s[k];
				if (!rot_z_s[k][Z_W-1]) begin
					rot_x_s[k+1] <= rot_x_s[k] - ys;
					rot_y_s[k+1] <= rot_y_s[k] + xs;
					rot_z_s[k+1] <= rot_z_s[k] - A;
				end else begin
					rot_x_s[k+1] <= rot_x_s[k] + ys;
					rot_y_s[k+1] <= rot_y_s[k] - xs;
					rot_z_s[k+1] <= rot_z_s[k] + A;
				end
			end
		end
	end

	// products L*cos, T*sin, L*sin
	logic                    mul_v_s, mul_zero_s;
	logic signed [PRD_W-1:0] mul_lx_s, mul_ty_s, mul_ly_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s <= 1'b0;
		end else if (adv) begin
			mul_v_s <= rot_v_s[N];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			mul_zero_s <= rot_zero_s[N];
			mul_lx_s   <= $signed({1'b0, wb_q}) * rot_x_s[N];
			mul_ty_s   <= $signed({1'b0, tr_q}) * rot_y_s[N];
			mul_ly_s   <= $signed({1'b0, wb_q}) * rot_y_s[N];
		end
	end

	// numerator and the two denominators
	logic                    den_v_s, den_zero_s;
	logic signed [DEN_W-1:0] den_num_s;
	logic signed [DEN_W-1:0] den_s [0:1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_v_s <= 1'b0;
		end else if (adv) begin
			den_v_s <= mul_v_s;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			den_zero_s <= mul_zero_s;
			den_num_s  <= DEN_W'(mul_ly_s) <<< 1;
			den_s[0]   <= DEN_W'(mul_lx_s) - DEN_W'(mul_ty_s);
			den_s[1]   <= DEN_W'(mul_lx_s) + DEN_W'(mul_ty_s);
		end
	end

	// vectoring CORDICs, side 0 right, side 1 left
	logic vec_v_s [0:N];
	logic vec_zero_s [0:N];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_v_s[0] <= 1'b0;
		end else if (adv) begin
			vec_v_s[0] <= den_v_s;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			vec_zero_s[0] <= den_zero_s;
		end
	end
	for (genvar k = 0; k < N; k++) begin : g_vctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vec_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				vec_v_s[k+1] <= vec_v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				vec_zero_s[k+1] <= vec_zero_s[k];
			end
		end
	end

	logic signed [ANG_W-1:0] rnd_ang_s [0:1];
	logic                    rnd_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_v_s <= 1'b0;
		end else if (adv) begin
			rnd_v_s <= vec_v_s[N];
		end
	end

	for (genvar sd = 0; sd < 2; sd++) begin : g_side
		logic signed [VEC_W-1:0] vx_s [0:N];
		logic signed [VEC_W-1:0] vy_s [0:N];
		logic signed [Z_W-1:0]   vz_s [0:N];
		logic                    vdz_s [0:N];
		logic signed [VEC_W-1:0] den_e, num_e;

		assign den_e = VEC_W'(den_s[sd]);
		assign num_e = VEC_W'(den_num_s);

		always_ff @(posedge clk) begin
			if (adv) begin
				vdz_s[0] <= (den_s[sd] == '0);
				vx_s[0]  <= den_e[VEC_W-1] ? -den_e : den_e;
				vy_s[0]  <= den_e[VEC_W-1] ? -num_e : num_e;
				vz_s[0]  <= '0;
			end
		end

		for (genvar k = 0; k < N; k++) begin : g_it
			localparam logic signed [Z_W-1:0] A = $signed({3'b0, atan_q16(k)});
			logic signed [VEC_W-1:0] xs, ys;
			assign xs = vx_s[k] >>> k;
			assign ys = vy_s[k] >>> k;
			always_ff @(posedge clk) begin
				if (adv) begin
					vdz_s[k+1] <= vdz_s[k];
					if (!vy_s[k][VEC_W-1]) begin
						vx_s[k+1] <= vx_s[k] + ys;
						vy_s[k+1] <= vy_s[k] - xs;
						vz_s[k+1] <= vz_s[k] + A;
					end else begin
						vx_s[k+1] <= vx_s[k] - ys;
						vy_s[k+1] <= vy_s[k] + xs;
						vz_s[k+1] <= vz_s[k] - A;
					end
				end
			end
		end

		// round Q.16 to Q8.8 and clamp
		logic signed [Z_W-1:0]   zr;
		logic signed [ANG_W-1:0] q;
		always_comb begin
			zr = (vz_s[N] + Z_W'(128)) >>> 8;
			if (zr > Z_W'(ANGLE_LIMIT)) q = ANGLE_LIMIT;
			else if (zr < -Z_W'(ANGLE_LIMIT)) q = -ANGLE_LIMIT;
			else q = zr[ANG_W-1:0];
			if (vdz_s[N]) q = ANGLE_LIMIT;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (vec_zero_s[N]) rnd_ang_s[sd] <= '0;
				else if (sd == 1) rnd_ang_s[sd] <= -q;
				else rnd_ang_s[sd] <= q;
			end
		end

		// restoring divider: |angle|*256 / dpp, one quotient bit a stage
		logic [DPP_W-1:0]        dv_rem_s [0:DVD_W];
		logic [DVD_W-1:0]        dv_dvd_s [0:DVD_W];
		logic [DVD_W-1:0]        dv_quo_s [0:DVD_W];
		logic signed [ANG_W-1:0] dv_ang_s [0:DVD_W];
		logic [MAG_W-1:0]        mag;
		logic signed [ANG_W-1:0] ang_abs;

		assign ang_abs = rnd_ang_s[sd][ANG_W-1] ? -rnd_ang_s[sd] : rnd_ang_s[sd];
		assign mag     = ang_abs[MAG_W-1:0];

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[0] <= '0;
				dv_dvd_s[0] <= {mag, 8'b0};
				dv_quo_s[0] <= '0;
				dv_ang_s[0] <= rnd_ang_s[sd];
			end
		end

		for (genvar k = 0; k < DVD_W; k++) begin : g_div
			logic [DPP_W:0]   t;
			logic [DPP_W+1:0] diff;
			assign t    = {dv_rem_s[k], dv_dvd_s[k][DVD_W-1]};
			assign diff = {1'b0, t} - {2'b0, dpp_q};
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_dvd_s[k+1] <= dv_dvd_s[k] << 1;
					dv_ang_s[k+1] <= dv_ang_s[k];
					if (!diff[DPP_W+1]) begin
						dv_rem_s[k+1] <= diff[DPP_W-1:0];
						dv_quo_s[k+1] <= {dv_quo_s[k][DVD_W-2:0], 1'b1};
					end else begin
						dv_rem_s[k+1] <= t[DPP_W-1:0];
						dv_quo_s[k+1] <= {dv_quo_s[k][DVD_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	logic dv_v_s [0:DVD_W];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= rnd_v_s;
		end
	end
	for (genvar k = 0; k < DVD_W; k++) begin : g_dvv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end
	end

	// saturate (covers zero degrees per pulse) and restore sign
	logic signed [PUL_W-1:0] pul [0:1];
	for (genvar sd = 0; sd < 2; sd++) begin : g_pul
		logic [DVD_W-1:0] p;
		always_comb begin
			p = g_side[sd].dv_quo_s[DVD_W];
			if (p > PULSE_LIMIT) p = PULSE_LIMIT;
			if (g_side[sd].dv_ang_s[DVD_W] == '0) pul[sd] = '0;
			else if (g_side[sd].dv_ang_s[DVD_W][ANG_W-1]) pul[sd] = -$signed({1'b0, p});
			else pul[sd] = $signed({1'b0, p});
		end
	end

	logic signed [ANG_W-1:0] res_r_ang_q, res_l_ang_q;
	logic signed [PUL_W-1:0] res_r_pul_q, res_l_pul_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= dv_v_s[DVD_W];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			res_r_ang_q <= g_side[0].dv_ang_s[DVD_W];
			res_l_ang_q <= g_side[1].dv_ang_s[DVD_W];
			res_r_pul_q <= pul[0];
			res_l_pul_q <= pul[1];
		end
	end

	assign res.valid        = res_valid_q;
	assign res.right_angle  = res_r_ang_q;
	assign res.left_angle   = res_l_ang_q;
	assign res.right_pulses = res_r_pul_q;
	assign res.left_pulses  = res_l_pul_q;

endmodule
